>>> design/c3ea_pkg.sv
package c3ea_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int COEF_BITS   = 16;
  localparam int KROW_BITS   = 3 * COEF_BITS;
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int WIDTH_BITS  = 11;
  localparam int ROW_BITS    = 12;
  localparam int HEIGHT_BITS = 13;
  localparam int ACC_BITS    = 28;
  localparam int RECIP_BITS  = 32;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [CFG_IDX_BITS-1:0] CFG_KERNEL_TOP    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_KERNEL_MID    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_KERNEL_BOTTOM = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT  = 3'd4;

  typedef struct packed {
    logic [7:0] pixel_in;
    logic       flush;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic shift;
    logic mac_step;
    logic div1;
    logic div2;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic do_shift;
    logic emit;
    logic mac_last;
    logic out_full;
  } dp_status_t;

  // floor(2^32 / n); for n = 1 the value falls one short and the
  // remainder correction restores the exact quotient
  function automatic logic [RECIP_BITS-1:0] recip(input logic [3:0] n);
    logic [RECIP_BITS-1:0] r;
    case (n)
      4'd1: r = 32'hFFFF_FFFF;
      4'd2: r = 32'h8000_0000;
      4'd3: r = 32'h5555_5555;
      4'd4: r = 32'h4000_0000;
      4'd5: r = 32'h3333_3333;
      4'd6: r = 32'h2AAA_AAAA;
      4'd7: r = 32'h2492_4924;
      4'd8: r = 32'h2000_0000;
      4'd9: r = 32'h1C71_C71C;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> design/c3ea_ctrl.sv
module c3ea_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  c3ea_pkg::dp_status_t  st,
  output c3ea_pkg::ctrl_cmd_t   cmd
);
  import c3ea_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_SHIFT = 7'b0000100,
    S_MAC   = 7'b0001000,
    S_DIV1  = 7'b0010000,
    S_DIV2  = 7'b0100000,
    S_PUT   = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (st.do_shift) state_next = S_READ;
        end
      end
      S_READ: state_next = S_SHIFT;
      S_SHIFT: begin
        cmd.shift = 1'b1;
        state_next = st.emit ? S_MAC : S_IDLE;
      end
      S_MAC: begin
        cmd.mac_step = 1'b1;
        if (st.mac_last) state_next = S_DIV1;
      end
      S_DIV1: begin
        cmd.div1 = 1'b1;
        state_next = S_DIV2;
      end
      S_DIV2: begin
        cmd.div2 = 1'b1;
        state_next = S_PUT;
      end
      S_PUT: begin
        if (!st.out_full) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> design/c3ea_datapath.sv
module c3ea_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  c3ea_pkg::in_item_t                   in_data,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output c3ea_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [c3ea_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [c3ea_pkg::KROW_BITS-1:0]       cfg_data,
  input  c3ea_pkg::ctrl_cmd_t                  cmd,
  output c3ea_pkg::dp_status_t                 st
);
  import c3ea_pkg::*;

  logic [KROW_BITS-1:0]   k_top, k_mid, k_bot;
  logic [WIDTH_BITS-1:0]  width_cfg, w_eff;
  logic [HEIGHT_BITS-1:0] height_cfg, h_eff;

  logic [COL_BITS-1:0]   in_column, out_column, drain_column, addr;
  logic [ROW_BITS-1:0]   in_row, out_row;
  logic [WIDTH_BITS-1:0] owed, fill;
  logic [7:0]            px_r, up_rd, mid_rd;
  logic                  emit_r;
  logic [7:0]            mem_up  [MAX_WIDTH];
  logic [7:0]            mem_mid [MAX_WIDTH];
  logic [7:0]            win [9];

  logic [1:0]                 row_i, col_j;
  logic signed [ACC_BITS-1:0] acc;
  logic [3:0]                 cnt;
  logic [ACC_BITS-1:0]        mag_r, q_r;
  logic                       neg_r;
  logic [7:0]                 res_r;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      k_top <= '0;
      k_mid <= '0;
      k_bot <= '0;
      width_cfg <= WIDTH_BITS'(MAX_WIDTH);
      height_cfg <= HEIGHT_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KERNEL_TOP:    k_top <= cfg_data;
        CFG_KERNEL_MID:    k_mid <= cfg_data;
        CFG_KERNEL_BOTTOM: k_bot <= cfg_data;
        CFG_IMAGE_WIDTH:   width_cfg <= cfg_data[WIDTH_BITS-1:0];
        CFG_IMAGE_HEIGHT:  height_cfg <= cfg_data[HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_cfg == '0) w_eff = WIDTH_BITS'(1);
    else if (width_cfg > WIDTH_BITS'(MAX_WIDTH)) w_eff = WIDTH_BITS'(MAX_WIDTH);
    else w_eff = width_cfg;
    h_eff = (height_cfg == '0) ? HEIGHT_BITS'(1) : height_cfg;
  end

  // input position bookkeeping
  logic [COL_BITS-1:0]   in_col_w, in_col_nx, drain_w, drain_nx;
  logic [ROW_BITS-1:0]   in_row_w, in_row_nx;
  logic [WIDTH_BITS-1:0] in_col_inc, drain_inc;
  logic [HEIGHT_BITS-1:0] in_row_inc;
  logic                  primed, flush_ok, fill_up;

  always_comb begin
    primed = {1'b0, fill} >= ({1'b0, w_eff} + (WIDTH_BITS+1)'(1));
    fill_up = !primed;
    flush_ok = (owed != '0) && (in_column == '0) && (in_row == '0);
    in_col_w = ({1'b0, in_column} >= w_eff) ? '0 : in_column;
    in_row_w = ({1'b0, in_row} >= h_eff) ? '0 : in_row;
    in_col_inc = {1'b0, in_col_w} + WIDTH_BITS'(1);
    in_row_inc = {1'b0, in_row_w} + HEIGHT_BITS'(1);
    if (in_col_inc >= w_eff) begin
      in_col_nx = '0;
      in_row_nx = (in_row_inc >= h_eff) ? '0 : in_row_inc[ROW_BITS-1:0];
    end else begin
      in_col_nx = in_col_inc[COL_BITS-1:0];
      in_row_nx = in_row_w;
    end
    drain_w = ({1'b0, drain_column} >= w_eff) ? '0 : drain_column;
    drain_inc = {1'b0, drain_w} + WIDTH_BITS'(1);
    drain_nx = (drain_inc >= w_eff) ? '0 : drain_inc[COL_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column <= '0;
      in_row <= '0;
      drain_column <= '0;
      owed <= '0;
      fill <= '0;
      emit_r <= 1'b0;
    end else if (cmd.accept) begin
      if (!in_data.flush) begin
        in_column <= in_col_nx;
        in_row <= in_row_nx;
        drain_column <= '0;
        owed <= owed + WIDTH_BITS'(1) - WIDTH_BITS'(primed);
        if (fill_up) fill <= fill + WIDTH_BITS'(1);
        emit_r <= primed;
      end else if (flush_ok) begin
        drain_column <= drain_nx;
        owed <= owed - WIDTH_BITS'(primed);
        if (fill_up) fill <= fill + WIDTH_BITS'(1);
        emit_r <= primed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      addr <= in_data.flush ? drain_w : in_col_w;
      px_r <= in_data.flush ? 8'd0 : in_data.pixel_in;
    end
  end

  // line stores: registered read, write back when the window shifts
  always_ff @(posedge clk) begin
    up_rd <= mem_up[addr];
    mid_rd <= mem_mid[addr];
    if (cmd.shift) begin
      mem_up[addr] <= mid_rd;
      mem_mid[addr] <= px_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 9; k++) win[k] <= '0;
    end else if (cmd.shift) begin
      for (int r = 0; r < 3; r++) begin
        win[r*3]   <= win[r*3+1];
        win[r*3+1] <= win[r*3+2];
      end
      win[2] <= up_rd;
      win[5] <= mid_rd;
      win[8] <= px_r;
    end
  end

  // multiply-accumulate over the nine cells
  logic [3:0]                  widx;
  logic [7:0]                  pix;
  logic [KROW_BITS-1:0]        krow;
  logic [1:0]                  csel;
  logic signed [COEF_BITS-1:0] coef;
  logic signed [COEF_BITS+8:0] prod;
  logic                        row_ok, col_ok;

  always_comb begin
    widx = {2'b00, row_i} * 4'd3 + {2'b00, col_j};
    pix = win[widx];
    case (row_i)
      2'd0: krow = k_bot;
      2'd1: krow = k_mid;
      default: krow = k_top;
    endcase
    csel = 2'd2 - col_j;
    coef = krow[csel*COEF_BITS +: COEF_BITS];
    prod = $signed({1'b0, pix}) * coef;
    case (row_i)
      2'd0: row_ok = (out_row != '0);
      2'd1: row_ok = 1'b1;
      2'd2: row_ok = ({1'b0, out_row} + HEIGHT_BITS'(1)) < h_eff;
      default: row_ok = 1'b0;
    endcase
    case (col_j)
      2'd0: col_ok = (out_column != '0);
      2'd1: col_ok = 1'b1;
      2'd2: col_ok = ({1'b0, out_column} + WIDTH_BITS'(1)) < w_eff;
      default: col_ok = 1'b0;
    endcase
  end

  // division by the cell count through a reciprocal
  logic [ACC_BITS-1:0]            mag, rem, qc;
  logic [ACC_BITS+RECIP_BITS-1:0] qprod;
  logic [ACC_BITS+3:0]            qn;
  logic [7:0]                     val8;

  always_comb begin
    mag = acc[ACC_BITS-1] ? ACC_BITS'(-acc) : ACC_BITS'(acc);
    qprod = mag * recip(cnt);
    qn = q_r * cnt;
    rem = mag_r - qn[ACC_BITS-1:0];
    qc = (rem >= ACC_BITS'(cnt)) ? q_r + ACC_BITS'(1) : q_r;
    if (cnt == '0) val8 = '0;
    else if (neg_r) val8 = 8'(-qc[7:0]);
    else val8 = qc[7:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      acc <= '0;
      cnt <= '0;
      row_i <= '0;
      col_j <= '0;
    end else if (cmd.mac_step) begin
      if (row_ok && col_ok) begin
        acc <= acc + ACC_BITS'(prod);
        cnt <= cnt + 4'd1;
      end
      if (col_j == 2'd2) begin
        col_j <= '0;
        row_i <= row_i + 2'd1;
      end else begin
        col_j <= col_j + 2'd1;
      end
    end
    if (cmd.div1) begin
      mag_r <= mag;
      neg_r <= acc[ACC_BITS-1];
      q_r <= qprod[ACC_BITS+RECIP_BITS-1:RECIP_BITS];
    end
    if (cmd.div2) res_r <= val8;
  end

  // output position and result register
  logic [WIDTH_BITS-1:0]  oc_inc;
  logic [HEIGHT_BITS-1:0] or_inc;

  always_comb begin
    oc_inc = {1'b0, out_column} + WIDTH_BITS'(1);
    or_inc = {1'b0, out_row} + HEIGHT_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_column <= '0;
      out_row <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.shift && emit_r) begin
        if ({1'b0, out_column} >= w_eff) out_column <= '0;
        if ({1'b0, out_row} >= h_eff) out_row <= '0;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
        if (oc_inc >= w_eff) begin
          out_column <= '0;
          out_row <= (or_inc >= h_eff) ? '0 : or_inc[ROW_BITS-1:0];
        end else begin
          out_column <= oc_inc[COL_BITS-1:0];
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.pixel_out <= res_r;
      out_data.frame_end <= (oc_inc >= w_eff) && (or_inc >= h_eff);
    end
  end

  always_comb begin
    st.do_shift = !in_data.flush || flush_ok;
    st.emit = emit_r;
    st.mac_last = (row_i == 2'd2) && (col_j == 2'd2);
    st.out_full = out_valid && !out_ready;
  end

endmodule

>>> design/conv3x3_edge_averaged.sv
// channel | direction | handshake             | payload
// --------+-----------+-----------------------+-------------------------------
// in      | input     | in_valid / in_ready   | in_data  {pixel_in, flush}
// out     | output    | out_valid / out_ready | out_data {pixel_out, frame_end}
// cfg     | input     | cfg_we                | cfg_index, cfg_data (48 bits)
//
// A pixel that yields a result passes through line store read, window
// shift, nine multiply-accumulate steps on one shared multiplier, two divide
// steps and output load; one that yields none stops after the window shift,
// and an ignored flush is only accepted. The nine-step MAC loop sets the rate.
// Reset is synchronous and active high; line stores are not cleared.
// A result waiting on out_ready stalls the final load, and no new
// pixel is taken in until that result is loaded.
module conv3x3_edge_averaged (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  c3ea_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output c3ea_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [c3ea_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [c3ea_pkg::KROW_BITS-1:0]     cfg_data
);
  import c3ea_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;

  // sequence each transfer: accept, read, shift, MAC, divide, load
  c3ea_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // hold line stores, window, counters, accumulator and result register
  c3ea_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st)
  );

`ifndef NO_ASSERTIONS
  // never overwrite a result that has not been transferred
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result overwritten before transfer");

  // no new transfer while the MAC loop runs
  a_busy_mac: assert property (@(posedge clk) disable iff (rst)
    cmd.mac_step |-> !in_ready)
    else $error("input ready during MAC");

  // a loaded result shows valid on the next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not valid");
`endif

endmodule
